>>> rtl/spwf_pkg.sv
// ----------------------------------------------------------------------------
// spwf_pkg: shared constants for the floored simplex projection block
// Configuration register indices and datapath widths.
// ----------------------------------------------------------------------------
package spwf_pkg;

    localparam logic [0:0] REG_TOTAL_SUM   = 1'b0;
    localparam logic [0:0] REG_FLOOR_VALUE = 1'b1;

    localparam int TOTAL_W = 31;
    localparam int FLOOR_W = 25;
    localparam int VAL_W   = 32;

endpackage

>>> rtl/spwf_div.sv
// ----------------------------------------------------------------------------
// spwf_div: restoring divider, one quotient bit per cycle
// Unsigned dividend by unsigned divisor; quotient rounded toward zero.
// ----------------------------------------------------------------------------
module spwf_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial;

    assign trial = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};

    // Shift-subtract iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                q_reg    <= num;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                if (trial >= {1'b0, den})
                begin
                    rem_reg <= trial - {1'b0, den};
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;
endmodule

>>> rtl/simplex_projection_with_floor_core.sv
// Flow: each element is placed by sorted insertion, which reads and moves one stored entry
// per step; the last element is followed by one adjustment step, a scan over the sorted
// elements, a divide (skipped when rho is zero) and one output transaction per stored element.
// Elements are taken one at a time; the next is accepted only once the last is inserted.
// Reset: asynchronous, active low; clears counters, restores register defaults; stores stay.
// ----------------------------------------------------------------------------
// simplex_projection_with_floor_core: floored simplex projection
// Stores shifted elements, sorts by insertion, finds theta and streams results.
// ----------------------------------------------------------------------------
module simplex_projection_with_floor_core #(
    parameter int MAX_LEN   = 64,
    parameter int FRAC_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] elem_value
    input  logic        s_axis_tlast,   // elem_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] proj_value
    output logic        m_axis_tlast,   // proj_last
    output logic        m_axis_tuser    // [0] truncated
);
    import spwf_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int NUM_W = 40;
    localparam logic [TOTAL_W-1:0] TOTAL_RST = TOTAL_W'(64'd1 << FRAC_BITS);
    localparam logic [FLOOR_W-1:0] FLOOR_RST =
        FLOOR_W'(((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000);

    typedef enum logic [2:0] {
        ST_IDLE, ST_INSERT, ST_ADJ, ST_SCAN, ST_DIV, ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [FLOOR_W-1:0] floor_reg;
    logic [31:0]        orig_mem [MAX_LEN];
    logic [31:0]        sort_mem [MAX_LEN];
    logic [CNT_W-1:0]   count_reg;
    logic               ovf_reg;
    logic [31:0]        s_reg;
    logic               last_reg;
    logic [CNT_W-1:0]   ptr_reg;
    logic [31:0]        rd_reg;
    logic               rd_ok_reg;
    logic signed [47:0] adj_reg, cum_reg, crho_reg;
    logic [CNT_W-1:0]   rho_reg;
    logic signed [31:0] theta_reg;
    logic               out_valid_reg, out_last_reg, out_trunc_reg;
    logic [31:0]        out_data_reg;
    logic [NUM_W-1:0]   quot;
    logic               div_start, div_busy, div_done;
    logic [47:0]        crho_mag;
    logic               in_fire;
    logic               emit_load;
    logic signed [33:0] shifted;
    logic signed [47:0] cval, v;
    logic [IDX_W-1:0]   ptr_idx, ptrm1_idx;

    assign cfg_ready     = (state_reg == ST_IDLE) && !out_valid_reg;
    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign shifted = 34'(signed'(s_axis_tdata)) - 34'(signed'({1'b0, floor_reg}));
    assign ptr_idx   = ptr_reg[IDX_W-1:0];
    assign ptrm1_idx = IDX_W'(ptr_reg - 1'b1);
    // One shared accumulate and compare per scan step.
    assign cval = cum_reg + 48'(rd_reg) - adj_reg;
    assign v    = 48'(rd_reg) - 48'(theta_reg);
    // The divider works on the magnitude; the sign is restored on the quotient.
    assign crho_mag  = crho_reg[47] ? -crho_reg : crho_reg;
    assign div_start = (state_reg == ST_SCAN) && (ptr_reg == count_reg) && (rho_reg != 0);
    assign emit_load = (state_reg == ST_EMIT) && (ptr_reg != count_reg) && rd_ok_reg &&
                       (!out_valid_reg || m_axis_tready);

    spwf_div #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(crho_mag[NUM_W-1:0]), .den(rho_reg),
        .busy(div_busy), .done(div_done), .quot(quot)
    );

    // Stores, read with a registered port.
    always_ff @(posedge clk)
    begin
        if (in_fire && count_reg < CNT_W'(MAX_LEN))
            orig_mem[count_reg[IDX_W-1:0]] <= shifted[33] ? 32'd0 : shifted[31:0];
        if (state_reg == ST_INSERT && rd_ok_reg)
        begin
            if (ptr_reg != 0 && rd_reg < s_reg)
                sort_mem[ptr_idx] <= rd_reg;
            else
                sort_mem[ptr_idx] <= s_reg;
        end
    end

    // Sequencer with registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= TOTAL_RST;
            floor_reg     <= FLOOR_RST;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TOTAL_SUM)
                    total_reg <= cfg_data[TOTAL_W-1:0];
                else
                    floor_reg <= cfg_data[FLOOR_W-1:0];
            end
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        s_reg     <= shifted[33] ? 32'd0 : shifted[31:0];
                        last_reg  <= s_axis_tlast;
                        ptr_reg   <= count_reg;
                        rd_ok_reg <= 1'b0;
                        if (count_reg < CNT_W'(MAX_LEN))
                            state_reg <= ST_INSERT;
                        else
                        begin
                            ovf_reg   <= 1'b1;
                            state_reg <= s_axis_tlast ? ST_ADJ : ST_IDLE;
                        end
                    end
                end
                ST_INSERT:
                begin
                    // Fetch sorted[ptr-1], then move it up or place the new one.
                    if (!rd_ok_reg)
                    begin
                        if (ptr_reg != 0)
                            rd_reg <= sort_mem[ptrm1_idx];
                        rd_ok_reg <= 1'b1;
                    end
                    else if (ptr_reg != 0 && rd_reg < s_reg)
                    begin
                        ptr_reg   <= ptr_reg - 1'b1;
                        rd_ok_reg <= 1'b0;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= last_reg ? ST_ADJ : ST_IDLE;
                    end
                end
                ST_ADJ:
                begin
                    adj_reg <= (48'(total_reg) < 48'(count_reg) * 48'(floor_reg)) ? '0 :
                        48'(total_reg) - 48'(count_reg) * 48'(floor_reg);
                    cum_reg   <= '0;
                    rho_reg   <= '0;
                    crho_reg  <= '0;
                    ptr_reg   <= '0;
                    rd_ok_reg <= 1'b0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    // Compare sorted[j]*(j+1) against the signed running excess.
                    if (ptr_reg == count_reg)
                        state_reg <= ST_DIV;
                    else if (!rd_ok_reg)
                    begin
                        rd_reg    <= sort_mem[ptr_idx];
                        rd_ok_reg <= 1'b1;
                    end
                    else
                    begin
                        cum_reg <= cum_reg + 48'(rd_reg);
                        if (signed'(48'(rd_reg) * 48'(ptr_reg + 1'b1)) > cval)
                        begin
                            rho_reg  <= ptr_reg + 1'b1;
                            crho_reg <= cval;
                        end
                        ptr_reg   <= ptr_reg + 1'b1;
                        rd_ok_reg <= 1'b0;
                    end
                end
                ST_DIV:
                begin
                    if (rho_reg == 0)
                        theta_reg <= '0;
                    else if (div_done)
                        theta_reg <= crho_reg[47] ? 32'd0 - quot[31:0] : quot[31:0];
                    if (rho_reg == 0 || div_done)
                    begin
                        ptr_reg   <= '0;
                        rd_ok_reg <= 1'b0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (ptr_reg == count_reg)
                    begin
                        if (!out_valid_reg)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (!rd_ok_reg)
                    begin
                        rd_reg    <= orig_mem[ptr_idx];
                        rd_ok_reg <= 1'b1;
                    end
                    else if (!out_valid_reg || m_axis_tready)
                    begin
                        out_data_reg  <= ((v[47] ? 48'(floor_reg) : v + 48'(floor_reg))
                                         > 48'h7FFFFFFF) ? 32'h7FFFFFFF :
                                         (v[47] ? 32'(floor_reg) : 32'(v + 48'(floor_reg)));
                        out_last_reg  <= (ptr_reg + 1'b1) == count_reg;
                        out_trunc_reg <= ovf_reg;
                        ptr_reg       <= ptr_reg + 1'b1;
                        rd_ok_reg     <= 1'b0;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_trunc_reg;

`ifndef NO_ASSERTIONS
    // No new element is taken while results are outstanding.
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !s_axis_tready) else $error("input accepted during output");
    // The divider only runs in the divide phase.
    a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == ST_DIV)) else $error("divider busy outside divide");
    // Stored count never exceeds capacity.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN)) else $error("element count overflow");
`endif
endmodule

>>> test/tb_simplex_projection_with_floor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_simplex_projection_with_floor_core: self-checking bench for the core
// Streams vectors of Q8.24 elements under random idling and checks every
// projected element against a bit-accurate software projection.
// ----------------------------------------------------------------------------
module tb_simplex_projection_with_floor_core;
    import spwf_pkg::*;

    localparam int VEC_CAP = 64;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } elem_t;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        trunc;
    } proj_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    // Predictor state.
    logic [30:0] pr_total;
    logic [24:0] pr_floor;
    logic [31:0] pr_orig [VEC_CAP];
    logic [31:0] pr_sorted [VEC_CAP];
    int          pr_count;
    bit          pr_overflow;

    elem_t pending_elems [$];
    proj_t expected_proj [$];
    int    error_count;
    bit    calm;
    int    send_gap;
    int    recv_gap;

    simplex_projection_with_floor_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one accepted element to the predictor, queueing any results.
    task automatic project_elem(input elem_t e);
        longint fl, s, adj, cum, c, crho, theta, v;
        int     i, rho;
        proj_t  r;
        fl = longint'(pr_floor);
        s = longint'($signed(e.value)) - fl;
        if (s < 0)
            s = 0;
        if (pr_count < VEC_CAP)
        begin
            i = pr_count;
            while (i > 0 && pr_sorted[i - 1] < s[31:0])
            begin
                pr_sorted[i] = pr_sorted[i - 1];
                i--;
            end
            pr_sorted[i] = s[31:0];
            pr_orig[pr_count] = s[31:0];
            pr_count++;
        end
        else
            pr_overflow = 1'b1;
        if (!e.last)
            return;
        adj = longint'(pr_total) - longint'(pr_count) * fl;
        if (adj < 0)
            adj = 0;
        cum = 0;
        crho = 0;
        rho = 0;
        for (i = 0; i < pr_count; i++)
        begin
            cum += longint'(pr_sorted[i]);
            c = cum - adj;
            if (longint'(pr_sorted[i]) * longint'(i + 1) > c)
            begin
                rho = i + 1;
                crho = c;
            end
        end
        theta = (rho > 0) ? crho / longint'(rho) : 0;
        for (i = 0; i < pr_count; i++)
        begin
            v = longint'(pr_orig[i]) - theta;
            if (v < 0)
                v = 0;
            v += fl;
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            r.value = v[31:0];
            r.last = (i + 1 == pr_count);
            r.trunc = pr_overflow;
            expected_proj.push_back(r);
        end
        pr_count = 0;
        pr_overflow = 1'b0;
    endtask

    // Register write while the block is idle.
    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_TOTAL_SUM)
            pr_total = val[30:0];
        else
            pr_floor = val[24:0];
    endtask

    // Wait until all queued elements are taken and all results have come back.
    task automatic drain();
        wait (pending_elems.size() == 0 && expected_proj.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_elem(input int style);
        case (style)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0200_0000);
            2: return 32'h0100_0000 + $signed($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
            default: return $urandom_range(0, 32'h0001_0000);
        endcase
    endfunction

    task automatic push_vector(input int len, input int style);
        elem_t e;
        for (int k = 0; k < len; k++)
        begin
            e.value = rand_elem(style);
            e.last = (k == len - 1);
            pending_elems.push_back(e);
        end
    endtask

    // Stimulus.
    initial
    begin
        elem_t e;
        int    len;
        error_count = 0;
        calm = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        pr_total = 31'd16777216;
        pr_floor = 25'd17;
        pr_count = 0;
        pr_overflow = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, single-element vector, equal elements.
        e.last = 1'b0; e.value = 32'h7FFF_FFFF; pending_elems.push_back(e);
        e.value = 32'h8000_0000; pending_elems.push_back(e);
        e.value = 32'h0000_0000; pending_elems.push_back(e);
        e.value = 32'hFFFF_FFFF; pending_elems.push_back(e);
        e.last = 1'b1; e.value = 32'h0080_0000; pending_elems.push_back(e);
        e.value = 32'h0100_0000; pending_elems.push_back(e);
        e.last = 1'b0; e.value = 32'h0040_0000; pending_elems.push_back(e);
        e.value = 32'h0040_0000; pending_elems.push_back(e);
        e.last = 1'b1; pending_elems.push_back(e);
        drain();

        // Floor above budget and extremes of both registers.
        write_reg(REG_FLOOR_VALUE, 32'h0100_0000);
        write_reg(REG_TOTAL_SUM, 32'hFFFF_FFFF);
        push_vector(4, 1);
        push_vector(3, 0);
        drain();
        write_reg(REG_TOTAL_SUM, 32'h0000_0000);
        write_reg(REG_FLOOR_VALUE, 32'hFFFF_FFFF);
        push_vector(3, 2);
        drain();
        write_reg(REG_FLOOR_VALUE, 32'h0000_0000);
        push_vector(2, 0);
        drain();

        // Overlong vector drops the tail.
        write_reg(REG_TOTAL_SUM, 32'h0100_0000);
        write_reg(REG_FLOOR_VALUE, 32'd17);
        push_vector(70, 1);
        drain();

        // Random vectors over several register settings.
        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(REG_TOTAL_SUM, $urandom);
            write_reg(REG_FLOOR_VALUE, (phase == 1) ? 32'd0 : $urandom_range(0, 32'h0100_0000));
            for (int v = 0; v < 12; v++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 66)
                                                  : $urandom_range(1, 8);
                push_vector(len, $urandom_range(0, 3));
            end
            if (phase == 3)
                calm = 1'b1;
            drain();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Driver: sends queued elements with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
            send_gap <= 0;
        end
        else if (s_axis_tvalid && !s_axis_tready)
        begin
        end
        else
        begin
            if (s_axis_tvalid)
                project_elem(pending_elems.pop_front());
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_elems.size() > 0)
            begin
                if (!calm && $urandom_range(0, 7) == 0)
                begin
                    send_gap <= $urandom_range(0, 8);
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_elems[0].value;
                    s_axis_tlast <= pending_elems[0].last;
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: random stalls on the result side and field checks.
    always @(posedge clk or negedge rst_n)
    begin
        proj_t exp_r;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_proj.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    exp_r = expected_proj.pop_front();
                    if (exp_r != {m_axis_tdata, m_axis_tlast, m_axis_tuser})
                    begin
                        $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                                 exp_r.value, exp_r.last, exp_r.trunc,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                        error_count++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                recv_gap <= $urandom_range(0, 8);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
